// ===== hw/rtl/alwr_pkg.sv =====
package alwr_pkg;

    // Request codes carried on req_type.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // Width of a pixel level.
    localparam int LEVEL_W = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_line;    // latch a new line from the input transfer
        logic div_step;     // one step of the slope division
        logic emit_first;   // load the first pixel of a step into the output register
        logic emit_second;  // load the second pixel of a Wu column and advance
    } alwr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic active;       // a line is loaded and not yet finished
        logic two_pix;      // the loaded line gives two pixels per step
        logic start_wu;     // the line on the input needs the slope division
        logic div_last;     // the division is on its final step
    } alwr_status_t;

endpackage

// ===== hw/rtl/antialiased_line_rasterizer_unit.sv =====
// Channel   Handshake                  Payload
// item      item_valid / item_stall    req_type, first_x, first_y, second_x, second_y,
//                                      first_level, second_level
// result    result_valid / result_stall pix_x, pix_y, level, last
//
// A start transfer loads the line; a line that is neither a point, axis-aligned nor
// an exact diagonal then forms FRAC_BITS quotient bits in the radix-2 slope divider.
// A step on a Wu line gives two pixels, one after the other through the single output
// register; point and unit-step lines give one pixel per cycle while the result side
// does not stall. The next item is taken in the cycle in which the final pixel of a step
// leaves. Reset is asynchronous and active low and leaves no line loaded. A stall on the
// result side holds the output register and stalls the item side.
module antialiased_line_rasterizer_unit
    import alwr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  req_type,
    input  logic [COORD_BITS-1:0] first_x,
    input  logic [COORD_BITS-1:0] first_y,
    input  logic [COORD_BITS-1:0] second_x,
    input  logic [COORD_BITS-1:0] second_y,
    input  logic [LEVEL_W-1:0]    first_level,
    input  logic [LEVEL_W-1:0]    second_level,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [COORD_BITS:0]   pix_x,
    output logic [COORD_BITS:0]   pix_y,
    output logic [LEVEL_W-1:0]    level,
    output logic                  last
);

    alwr_cmd_t    cmd;
    alwr_status_t status;

    // The controller sequences start, division and the one or two pixels of each step.
    alwr_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .req_type     (req_type),
        .result_stall (result_stall),
        .status       (status),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    // The datapath holds the line state, the slope divider and the output register.
    alwr_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .first_x      (first_x),
        .first_y      (first_y),
        .second_x     (second_x),
        .second_y     (second_y),
        .first_level  (first_level),
        .second_level (second_level),
        .status       (status),
        .pix_x        (pix_x),
        .pix_y        (pix_y),
        .level        (level),
        .last         (last)
    );

endmodule

// ===== hw/rtl/alwr_ctrl.sv =====
module alwr_ctrl
    import alwr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  logic         req_type,
    input  logic         result_stall,
    input  alwr_status_t status,
    output logic         item_stall,
    output logic         result_valid,
    output alwr_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_PIX0 = 4'b0100,
        S_PIX1 = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   item_ready;
    logic   item_xfer;
    logic   result_xfer;

    assign result_valid = (state_reg == S_PIX0) || (state_reg == S_PIX1);
    assign result_xfer  = result_valid && !result_stall;

    // A new item may enter in the same cycle as the final pixel of a step leaves.
    assign item_ready = (state_reg == S_IDLE)
                     || ((state_reg == S_PIX1) && !result_stall)
                     || ((state_reg == S_PIX0) && !status.two_pix && !result_stall);
    assign item_stall = !item_ready;
    assign item_xfer  = item_valid && item_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        if (item_xfer)
        begin
            if (req_type == REQ_START)
            begin
                cmd.load_line = 1'b1;
                state_next    = status.start_wu ? S_DIV : S_IDLE;
            end
            else if (status.active)
            begin
                cmd.emit_first = 1'b1;
                state_next     = S_PIX0;
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
        else
        begin
            case (state_reg)
                S_DIV:
                begin
                    cmd.div_step = 1'b1;
                    if (status.div_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
                S_PIX0:
                begin
                    if (result_xfer)
                    begin
                        if (status.two_pix)
                        begin
                            cmd.emit_second = 1'b1;
                            state_next      = S_PIX1;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                S_PIX1:
                begin
                    if (result_xfer)
                    begin
                        state_next = S_IDLE;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/alwr_dp.sv =====
module alwr_dp
    import alwr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  alwr_cmd_t            cmd,
    input  logic [COORD_BITS-1:0] first_x,
    input  logic [COORD_BITS-1:0] first_y,
    input  logic [COORD_BITS-1:0] second_x,
    input  logic [COORD_BITS-1:0] second_y,
    input  logic [LEVEL_W-1:0]   first_level,
    input  logic [LEVEL_W-1:0]   second_level,
    output alwr_status_t         status,
    output logic [COORD_BITS:0]  pix_x,
    output logic [COORD_BITS:0]  pix_y,
    output logic [LEVEL_W-1:0]   level,
    output logic                 last
);

    localparam int CW   = COORD_BITS;
    localparam int FW   = FRAC_BITS;
    localparam int AW   = CW + FW;
    localparam int CNTW = $clog2(FW);

    // Line set-up from the input endpoints.
    logic signed [CW:0] dx;
    logic signed [CW:0] dy;
    logic [CW:0]        adx;
    logic [CW:0]        ady;
    logic               in_steep;
    logic               in_lone;
    logic               in_walk;
    logic [CW-1:0]      maj1;
    logic [CW-1:0]      maj2;
    logic [CW-1:0]      min1;
    logic [CW-1:0]      min2;
    logic               swap;
    logic [CW-1:0]      a1;
    logic [CW-1:0]      a2;
    logic [CW-1:0]      b1;
    logic [CW-1:0]      b2;
    logic signed [CW:0] db;
    logic [CW:0]        adb;

    // Line state.
    logic               active_reg;
    logic               wu_reg;
    logic               lone_reg;
    logic               steep_reg;
    logic [CW-1:0]      major_pos_reg;
    logic [CW-1:0]      major_end_reg;
    logic [CW-1:0]      walk_minor_reg;
    logic               maj_down_reg;
    logic               min_move_reg;
    logic               min_down_reg;
    logic [AW-1:0]      acc_reg;
    logic [CW-1:0]      end_x_reg;
    logic [CW-1:0]      end_y_reg;
    logic [LEVEL_W-1:0] end_lvl_reg;

    // Slope divider.
    logic [CW-1:0]      rem_reg;
    logic [CW-1:0]      dvs_reg;
    logic [FW-1:0]      quo_reg;
    logic               neg_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic [CW:0]        rem_dbl;
    logic [CW:0]        rem_diff;
    logic               rem_ge;
    logic [AW-1:0]      quo_ext;
    logic [AW-1:0]      slope_ext;

    // Pixel generation.
    logic               fin;
    logic [CW-1:0]      acc_int;
    logic [FW-1:0]      acc_frac;
    logic [CW:0]        acc_int_up;
    logic [FW+7:0]      lo_prod;
    logic [FW:0]        frac_inv;
    logic [FW+8:0]      hi_prod;
    logic [LEVEL_W-1:0] lo_lvl;
    logic [LEVEL_W-1:0] hi_lvl;
    logic [CW-1:0]      walk_major_next;
    logic [CW-1:0]      walk_minor_next;

    // Output register.
    logic [CW:0]        out_x_reg;
    logic [CW:0]        out_y_reg;
    logic [LEVEL_W-1:0] out_lvl_reg;
    logic               out_last_reg;
    logic [CW:0]        out_x_next;
    logic [CW:0]        out_y_next;
    logic [LEVEL_W-1:0] out_lvl_next;
    logic               out_last_next;

    assign dx  = $signed({1'b0, second_x}) - $signed({1'b0, first_x});
    assign dy  = $signed({1'b0, second_y}) - $signed({1'b0, first_y});
    assign adx = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
    assign ady = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);

    assign in_steep = ady > adx;
    assign in_lone  = (dx == '0) && (dy == '0);
    assign in_walk  = (dx == '0) || (dy == '0) || (adx == ady);

    assign maj1 = in_steep ? first_y  : first_x;
    assign min1 = in_steep ? first_x  : first_y;
    assign maj2 = in_steep ? second_y : second_x;
    assign min2 = in_steep ? second_x : second_y;

    // Wu lines always run towards increasing major position.
    assign swap = maj1 > maj2;
    assign a1   = swap ? maj2 : maj1;
    assign a2   = swap ? maj1 : maj2;
    assign b1   = swap ? min2 : min1;
    assign b2   = swap ? min1 : min2;
    assign db   = $signed({1'b0, b2}) - $signed({1'b0, b1});
    assign adb  = db[CW] ? (CW+1)'(-db) : (CW+1)'(db);

    // Restoring division of |db| * 2^FW by the major span, one quotient bit per step.
    // The remainder always stays below the divisor.
    assign rem_dbl  = {rem_reg, 1'b0};
    assign rem_diff = rem_dbl - {1'b0, dvs_reg};
    assign rem_ge   = rem_dbl >= {1'b0, dvs_reg};

    assign quo_ext   = {{CW{1'b0}}, quo_reg};
    assign slope_ext = neg_reg ? AW'(-quo_ext) : quo_ext;

    assign acc_int    = acc_reg[AW-1:FW];
    assign acc_frac   = acc_reg[FW-1:0];
    assign acc_int_up = {1'b0, acc_int} + (CW+1)'(1);

    // Levels are 255 * fraction, truncated, for the lower pixel and the complement above.
    assign lo_prod  = {acc_frac, 8'b0} - {8'b0, acc_frac};
    assign frac_inv = {1'b1, {FW{1'b0}}} - {1'b0, acc_frac};
    assign hi_prod  = {frac_inv, 8'b0} - {8'b0, frac_inv};
    assign lo_lvl   = lo_prod[FW+7:FW];
    assign hi_lvl   = hi_prod[FW+7:FW];

    assign fin = major_pos_reg == major_end_reg;

    assign walk_major_next = maj_down_reg ? major_pos_reg - CW'(1) : major_pos_reg + CW'(1);
    assign walk_minor_next = !min_move_reg ? walk_minor_reg
                           : (min_down_reg ? walk_minor_reg - CW'(1)
                                           : walk_minor_reg + CW'(1));

    always_comb
    begin
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        out_lvl_next  = out_lvl_reg;
        out_last_next = out_last_reg;
        if (cmd.emit_first)
        begin
            if (lone_reg)
            begin
                out_x_next    = {1'b0, end_x_reg};
                out_y_next    = {1'b0, end_y_reg};
                out_lvl_next  = end_lvl_reg;
                out_last_next = 1'b1;
            end
            else if (!wu_reg)
            begin
                out_x_next    = {1'b0, steep_reg ? walk_minor_reg : major_pos_reg};
                out_y_next    = {1'b0, steep_reg ? major_pos_reg : walk_minor_reg};
                out_lvl_next  = '0;
                out_last_next = fin;
            end
            else
            begin
                out_x_next    = {1'b0, steep_reg ? acc_int : major_pos_reg};
                out_y_next    = {1'b0, steep_reg ? major_pos_reg : acc_int};
                out_lvl_next  = lo_lvl;
                out_last_next = 1'b0;
            end
        end
        else if (cmd.emit_second)
        begin
            if (fin)
            begin
                out_x_next    = {1'b0, end_x_reg};
                out_y_next    = {1'b0, end_y_reg};
                out_lvl_next  = end_lvl_reg;
                out_last_next = 1'b1;
            end
            else
            begin
                out_x_next    = steep_reg ? acc_int_up : {1'b0, major_pos_reg};
                out_y_next    = steep_reg ? {1'b0, major_pos_reg} : acc_int_up;
                out_lvl_next  = hi_lvl;
                out_last_next = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            wu_reg     <= 1'b0;
            lone_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cmd.load_line)
            begin
                active_reg <= 1'b1;
                lone_reg   <= in_lone;
                wu_reg     <= !in_lone && !in_walk;
                cnt_reg    <= '0;
            end
            else
            begin
                if (cmd.div_step)
                begin
                    cnt_reg <= cnt_reg + CNTW'(1);
                end
                if (cmd.emit_first && (lone_reg || (!wu_reg && fin)))
                begin
                    active_reg <= 1'b0;
                end
                if (cmd.emit_second && fin)
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    // Line geometry, divider and output payload.
    always_ff @(posedge clk)
    begin
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_lvl_reg  <= out_lvl_next;
        out_last_reg <= out_last_next;
        if (cmd.load_line)
        begin
            steep_reg      <= in_steep;
            walk_minor_reg <= min1;
            maj_down_reg   <= maj2 < maj1;
            min_move_reg   <= min2 != min1;
            min_down_reg   <= min2 < min1;
            acc_reg        <= {b1, {FW{1'b0}}};
            rem_reg        <= adb[CW-1:0];
            dvs_reg        <= a2 - a1;
            neg_reg        <= db[CW];
            quo_reg        <= '0;
            if (in_lone)
            begin
                end_x_reg   <= first_x;
                end_y_reg   <= first_y;
                end_lvl_reg <= first_level;
            end
            else
            begin
                end_x_reg   <= second_x;
                end_y_reg   <= second_y;
                end_lvl_reg <= second_level;
            end
            if (in_walk)
            begin
                major_pos_reg <= maj1;
                major_end_reg <= maj2;
            end
            else
            begin
                major_pos_reg <= a1;
                major_end_reg <= a2;
            end
        end
        else
        begin
            if (cmd.div_step)
            begin
                rem_reg <= rem_ge ? rem_diff[CW-1:0] : rem_dbl[CW-1:0];
                quo_reg <= {quo_reg[FW-2:0], rem_ge};
            end
            if (cmd.emit_first && !lone_reg && !wu_reg && !fin)
            begin
                major_pos_reg  <= walk_major_next;
                walk_minor_reg <= walk_minor_next;
            end
            if (cmd.emit_second && !fin)
            begin
                major_pos_reg <= major_pos_reg + CW'(1);
                acc_reg       <= acc_reg + slope_ext;
            end
        end
    end

    assign status.active   = active_reg;
    assign status.two_pix  = wu_reg;
    assign status.start_wu = !in_lone && !in_walk;
    assign status.div_last = cnt_reg == CNTW'(FW - 1);

    assign pix_x = out_x_reg;
    assign pix_y = out_y_reg;
    assign level = out_lvl_reg;
    assign last  = out_last_reg;

endmodule

// ===== tb/sv/tb_antialiased_line_rasterizer_unit.sv =====
`timescale 1ns / 1ps

module tb_antialiased_line_rasterizer_unit
    import alwr_pkg::*;
();

    localparam int     CB             = 12;
    localparam int     FB             = 16;
    localparam longint FONE           = longint'(1) << FB;
    localparam int     WATCHDOG_LIMIT = 1000;
    localparam int     RANDOM_ITEMS   = 1000;
    // This covers any slope division still in flight after the last start.
    localparam int     DRAIN_CYCLES   = 40;

    // One request as it crosses the item channel.
    typedef struct packed {
        logic               req;
        logic [CB-1:0]      x1;
        logic [CB-1:0]      y1;
        logic [CB-1:0]      x2;
        logic [CB-1:0]      y2;
        logic [LEVEL_W-1:0] lvl1;
        logic [LEVEL_W-1:0] lvl2;
    } line_req_t;

    // One pixel as it crosses the result channel.
    typedef struct packed {
        logic [CB:0]        x;
        logic [CB:0]        y;
        logic [LEVEL_W-1:0] lvl;
        logic               fin;
    } pixel_t;

    // A row of the directed script. A negative pixel count leaves the expectation to the
    // line tracker; otherwise the row carries that many typed-in pixels (none or one).
    typedef struct {
        line_req_t req;
        int        n_typed;
        pixel_t    px;
    } script_row_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    logic               req_type     = REQ_STEP;
    logic [CB-1:0]      first_x      = '0;
    logic [CB-1:0]      first_y      = '0;
    logic [CB-1:0]      second_x     = '0;
    logic [CB-1:0]      second_y     = '0;
    logic [LEVEL_W-1:0] first_level  = '0;
    logic [LEVEL_W-1:0] second_level = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [CB:0]        pix_x;
    logic [CB:0]        pix_y;
    logic [LEVEL_W-1:0] level;
    logic               last;

    // Copy of the line currently being drawn, as the block should hold it.
    bit          ln_active;
    bit          ln_wu;
    bit          ln_steep;
    bit          ln_point;
    int          maj_pos;
    int          maj_end;
    int          walk_min;
    int          step_maj;
    int          step_min;
    longint      min_acc;
    longint      grad;
    pixel_t      ln_end;

    pixel_t      column_px[$];
    pixel_t      pending_pixels[$];
    script_row_t script[$];

    int          errors;
    int          items_sent;
    int          stall_left;
    int          quiet_cycles;
    bit          src_idle;
    bit          sink_idle;

    always #10 clk = ~clk;

    antialiased_line_rasterizer_unit #(
        .COORD_BITS (CB),
        .FRAC_BITS  (FB)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .req_type     (req_type),
        .first_x      (first_x),
        .first_y      (first_y),
        .second_x     (second_x),
        .second_y     (second_y),
        .first_level  (first_level),
        .second_level (second_level),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pix_x        (pix_x),
        .pix_y        (pix_y),
        .level        (level),
        .last         (last)
    );

    function automatic int magnitude(int a);
        return (a < 0) ? -a : a;
    endfunction

    function automatic int direction(int a);
        return (a > 0) ? 1 : ((a < 0) ? -1 : 0);
    endfunction

    function automatic pixel_t pixel_of(int x, int y, logic [LEVEL_W-1:0] lvl, logic fin);
        pixel_t p;
        p.x   = x[CB:0];
        p.y   = y[CB:0];
        p.lvl = lvl;
        p.fin = fin;
        return p;
    endfunction

    // Maps a (major, minor) position back to screen axes for the current line.
    function automatic pixel_t place(int major, int minor, logic [LEVEL_W-1:0] lvl, logic fin);
        return ln_steep ? pixel_of(minor, major, lvl, fin) : pixel_of(major, minor, lvl, fin);
    endfunction

    // Queue helpers: each adds one entry at the tail.
    function automatic void add_row(script_row_t row);
        script.insert(script.size(), row);
    endfunction

    function automatic void add_column_px(pixel_t p);
        column_px.insert(column_px.size(), p);
    endfunction

    function automatic void book_pixel(pixel_t p);
        pending_pixels.insert(pending_pixels.size(), p);
    endfunction

    function automatic line_req_t random_fields(logic req);
        line_req_t r;
        r.req  = req;
        r.x1   = CB'($urandom);
        r.y1   = CB'($urandom);
        r.x2   = CB'($urandom);
        r.y2   = CB'($urandom);
        r.lvl1 = LEVEL_W'($urandom);
        r.lvl2 = LEVEL_W'($urandom);
        return r;
    endfunction

    // Moves a coordinate by d, turning back at the edge of the coordinate range.
    function automatic logic [CB-1:0] offset(logic [CB-1:0] base, int d);
        int moved;
        moved = int'(base) + d;
        if (moved < 0 || moved >= (1 << CB))
            moved = int'(base) - d;
        return moved[CB-1:0];
    endfunction

    // Mostly back to back, some short gaps and the odd long one.
    function automatic int pick_gap(bit enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Line tracker: updates the copy of the line for one accepted request and leaves the
    // pixels it gives in column_px.
    task automatic rasterise(input line_req_t r);
        int                 x1, y1, x2, y2, dx, dy, a1, b1, a2, b2;
        longint             frac, top;
        logic [LEVEL_W-1:0] lo_lvl, hi_lvl;
        bit                 fin;
        column_px.delete();
        if (r.req == REQ_START)
        begin
            x1 = int'(r.x1);
            y1 = int'(r.y1);
            x2 = int'(r.x2);
            y2 = int'(r.y2);
            dx = x2 - x1;
            dy = y2 - y1;
            ln_active = 1'b1;
            ln_point  = 1'b0;
            ln_end    = pixel_of(x2, y2, r.lvl2, 1'b1);
            if (dx == 0 && dy == 0)
            begin
                // A single point comes back as the first endpoint with its own level.
                ln_point = 1'b1;
                ln_wu    = 1'b0;
                ln_end   = pixel_of(x1, y1, r.lvl1, 1'b1);
            end
            else
            begin
                ln_steep = magnitude(dy) > magnitude(dx);
                if (dx == 0 || dy == 0 || magnitude(dx) == magnitude(dy))
                begin
                    ln_wu    = 1'b0;
                    maj_pos  = ln_steep ? y1 : x1;
                    maj_end  = ln_steep ? y2 : x2;
                    walk_min = ln_steep ? x1 : y1;
                    step_maj = direction(ln_steep ? dy : dx);
                    step_min = direction(ln_steep ? dx : dy);
                end
                else
                begin
                    ln_wu = 1'b1;
                    a1 = ln_steep ? y1 : x1;
                    b1 = ln_steep ? x1 : y1;
                    a2 = ln_steep ? y2 : x2;
                    b2 = ln_steep ? x2 : y2;
                    if (a1 > a2)
                    begin
                        {a1, a2} = {a2, a1};
                        {b1, b2} = {b2, b1};
                    end
                    // Signed division truncates toward zero, as the block's divider does.
                    grad    = (longint'(b2 - b1) * FONE) / longint'(a2 - a1);
                    min_acc = longint'(b1) * FONE;
                    maj_pos = a1;
                    maj_end = a2;
                end
            end
        end
        else if (ln_active)
        begin
            fin = (maj_pos == maj_end);
            if (ln_point)
            begin
                add_column_px(ln_end);
                ln_active = 1'b0;
            end
            else if (!ln_wu)
            begin
                add_column_px(place(maj_pos, walk_min, '0, fin));
                if (fin)
                    ln_active = 1'b0;
                else
                begin
                    maj_pos  += step_maj;
                    walk_min += step_min;
                end
            end
            else
            begin
                frac   = min_acc & (FONE - 1);
                top    = min_acc >>> FB;
                lo_lvl = LEVEL_W'((255 * frac) >>> FB);
                hi_lvl = LEVEL_W'((255 * (FONE - frac)) >>> FB);
                add_column_px(place(maj_pos, int'(top), lo_lvl, 1'b0));
                if (fin)
                begin
                    // The last column closes on the second endpoint and its level.
                    add_column_px(ln_end);
                    ln_active = 1'b0;
                end
                else
                begin
                    add_column_px(place(maj_pos, int'(top) + 1, hi_lvl, 1'b0));
                    maj_pos++;
                    min_acc += grad;
                end
            end
        end
    endtask

    // Offers one request, waits for its transfer and books the pixels it should give.
    task automatic send(input line_req_t r, input int n_typed, input pixel_t typed);
        int gap;
        gap = pick_gap(src_idle);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid   <= 1'b1;
        req_type     <= r.req;
        first_x      <= r.x1;
        first_y      <= r.y1;
        second_x     <= r.x2;
        second_y     <= r.y2;
        first_level  <= r.lvl1;
        second_level <= r.lvl2;
        do
            @(posedge clk);
        while (item_stall);
        // Steps that find no line are ignored by the block and are not counted.
        if (r.req == REQ_START || ln_active)
            items_sent++;
        rasterise(r);
        if (n_typed < 0)
        begin
            foreach (column_px[i])
                book_pixel(column_px[i]);
        end
        else if (n_typed == 1)
            book_pixel(typed);
    endtask

    // One random line. Most are short, well-formed lines walked to their end; a few are
    // dropped part way by the next start, and a few span the whole coordinate range.
    task automatic random_line();
        line_req_t r;
        int        kind, len, run_major, run_minor, dx, dy, budget;
        r = random_fields(REQ_START);
        if ($urandom_range(0, 19) != 0)
        begin
            kind      = $urandom_range(0, 99);
            len       = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 8)
                                                    : $urandom_range(9, 64);
            run_major = len;
            run_minor = 0;
            if (kind < 5)
                run_major = 0;
            else if (kind >= 20 && kind < 35)
                run_minor = len;
            else if (kind >= 35)
            begin
                run_major = len + 1;
                run_minor = $urandom_range(1, len);
            end
            if ($urandom_range(0, 1))
            begin
                dx = run_major;
                dy = run_minor;
            end
            else
            begin
                dx = run_minor;
                dy = run_major;
            end
            if ($urandom_range(0, 1))
                dx = -dx;
            if ($urandom_range(0, 1))
                dy = -dy;
            r.x2   = offset(r.x1, dx);
            r.y2   = offset(r.y1, dy);
            budget = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : (1 << 20);
        end
        else
            budget = $urandom_range(0, 6);
        send(r, -1, '0);
        while (ln_active && budget > 0)
        begin
            send(random_fields(REQ_STEP), -1, '0);
            budget--;
        end
        // Now and then one more step: either idle or carrying on with a dropped line.
        if ($urandom_range(0, 9) == 0)
            send(random_fields(REQ_STEP), -1, '0);
    endtask

    function automatic script_row_t start_row(int x1, int y1, int x2, int y2,
                                              logic [LEVEL_W-1:0] l1, logic [LEVEL_W-1:0] l2);
        script_row_t row;
        row.req.req  = REQ_START;
        row.req.x1   = x1[CB-1:0];
        row.req.y1   = y1[CB-1:0];
        row.req.x2   = x2[CB-1:0];
        row.req.y2   = y2[CB-1:0];
        row.req.lvl1 = l1;
        row.req.lvl2 = l2;
        row.n_typed  = 0;
        row.px       = '0;
        return row;
    endfunction

    function automatic script_row_t step_row(int n_typed, pixel_t px);
        script_row_t row;
        row.req     = random_fields(REQ_STEP);
        row.n_typed = n_typed;
        row.px      = px;
        return row;
    endfunction

    // Result side: checks every transfer against the oldest booked pixel and, when sink
    // idling is on, stalls at random in between.
    always @(posedge clk)
    begin : result_sink
        pixel_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel (%0d, %0d) level %0d arrived with none expected",
                       pix_x, pix_y, level);
                errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("pix_x", 16'(want.x), 16'(pix_x));
                check_field("pix_y", 16'(want.y), 16'(pix_y));
                check_field("level", 16'(want.lvl), 16'(level));
                check_field("last", 16'(want.fin), 16'(last));
            end
        end
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            result_stall <= 1'b0;
            stall_left = pick_gap(sink_idle);
        end
    end

    // Ends the run if neither channel completes a transfer for too long.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_antialiased_line_rasterizer_unit: errors");
                $finish;
            end
        end
    end

    initial
    begin
        // Directed script: idle steps, a point at the top corner, short horizontal and
        // vertical walks, a full-range diagonal dropped by a new start, Wu lines both
        // shallow and steep (one run to its end so the final pixel is replaced), and a
        // Wu line whose upper pixel lands one past the coordinate range.
        add_row(step_row(0, '0));
        add_row(start_row(4095, 4095, 4095, 4095, 8'hA5, 8'h5A));
        add_row(step_row(1, pixel_of(4095, 4095, 8'hA5, 1'b1)));
        add_row(step_row(0, '0));
        add_row(start_row(0, 0, 2, 0, 8'hFF, 8'hFF));
        add_row(step_row(1, pixel_of(0, 0, '0, 1'b0)));
        add_row(step_row(1, pixel_of(1, 0, '0, 1'b0)));
        add_row(step_row(1, pixel_of(2, 0, '0, 1'b1)));
        add_row(start_row(7, 4095, 7, 4094, 8'h33, 8'hCC));
        add_row(step_row(1, pixel_of(7, 4095, '0, 1'b0)));
        add_row(step_row(1, pixel_of(7, 4094, '0, 1'b1)));
        add_row(start_row(4095, 0, 0, 4095, 8'h80, 8'h01));
        add_row(step_row(1, pixel_of(4095, 0, '0, 1'b0)));
        add_row(step_row(1, pixel_of(4094, 1, '0, 1'b0)));
        add_row(start_row(0, 0, 2, 1, 8'h00, 8'hFF));
        add_row(step_row(-1, '0));
        add_row(step_row(-1, '0));
        add_row(step_row(-1, '0));
        add_row(start_row(4095, 4095, 4094, 0, 8'h11, 8'h80));
        add_row(step_row(-1, '0));
        add_row(step_row(-1, '0));
        add_row(start_row(0, 4095, 4095, 4094, 8'h7F, 8'hFE));
        add_row(step_row(-1, '0));
        add_row(start_row(0, 0, 0, 0, 8'h00, 8'hFF));
        add_row(step_row(1, pixel_of(0, 0, 8'h00, 1'b1)));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        src_idle  = 1'b1;
        sink_idle = 1'b1;
        foreach (script[i])
            send(script[i].req, script[i].n_typed, script[i].px);

        // Random lines. Idling is switched every 128 items on the item side and every 256 on
        // the result side, so that the run has stretches with none, with gaps on one side only, and with both.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            src_idle  = ((items_sent >> 7) & 1) != 0;
            sink_idle = ((items_sent >> 8) & 1) != 0;
            random_line();
        end
        item_valid <= 1'b0;

        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb_antialiased_line_rasterizer_unit: clean");
        else
            $display("tb_antialiased_line_rasterizer_unit: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/alwr_pkg.sv
hw/rtl/alwr_ctrl.sv
hw/rtl/alwr_dp.sv
hw/rtl/antialiased_line_rasterizer_unit.sv
tb/sv/tb_antialiased_line_rasterizer_unit.sv
